// File: rtl/beam_dot_product_gain_clamp_unit_assert.svh
// Assertion macros shared by the beam dot-product RTL.
// Plain text, no dependencies; pulled in by `include where checks are written.
`ifndef BEAM_DOT_PRODUCT_GAIN_CLAMP_UNIT_ASSERT_SVH
`define BEAM_DOT_PRODUCT_GAIN_CLAMP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BEAMDP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("beamdp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BEAMDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("beamdp: next-cycle check failed");

`endif

// File: rtl/beamdp_pkg.sv
// Shared widths, types and constants for the beam dot-product unit.
// No dependencies; imported by the interfaces and every module.
package beamdp_pkg;

  localparam int SAMPLE_W  = 4;
  localparam int TERM_W    = 2 * SAMPLE_W;
  localparam int ACC_W     = 20;
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 16;
  localparam int PROD_W    = GAIN_W + ACC_W;
  localparam int QF_W      = PROD_W - GAIN_FRAC;
  localparam int OUT_W     = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [ACC_W-1:0]    sum_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [QF_W-1:0]     qfloor_t;
  typedef logic signed [OUT_W-1:0]    beam_t;

  localparam beam_t OUT_MAX = beam_t'(7);
  localparam beam_t OUT_MIN = beam_t'(-7);

  // Completed sum with its gain, waiting for the multiply.
  typedef struct packed {
    logic  valid;
    sum_t  sum;
    gain_t gain;
  } sum_stage_t;

  // Gained product with the raw sum, waiting for round and clamp.
  typedef struct packed {
    logic  valid;
    prod_t prod;
    sum_t  sum;
  } prod_stage_t;

endpackage

// File: rtl/beamdp_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on beamdp_pkg for field types.
interface beamdp_in_if
  import beamdp_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t weight;
  sample_t sample;
  gain_t   gain;
  logic    last;

  modport source (output valid, weight, sample, gain, last, input ready);
  modport sink (input valid, weight, sample, gain, last, output ready);
endinterface

interface beamdp_out_if
  import beamdp_pkg::*;
  ();
  logic  valid;
  logic  ready;
  beam_t beam_value;
  sum_t  raw_sum;

  modport source (output valid, beam_value, raw_sum, input ready);
  modport sink (input valid, beam_value, raw_sum, output ready);
endinterface

// File: rtl/beamdp_acc.sv
// Input stage: multiply-accumulate of weight*sample, hands the finished sum on.
// Depends on beamdp_pkg and beamdp_in_if.
module beamdp_acc
  import beamdp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  beamdp_in_if.sink     items,
  input  logic          ready_down,
  output sum_stage_t    stage
);

  sum_t  accumulator;
  term_t term;
  sum_t  sum_next;
  logic  accept;

  assign items.ready = !stage.valid || ready_down;
  assign accept      = items.valid && items.ready;
  assign term        = items.weight * items.sample;
  assign sum_next    = accumulator + sum_t'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      stage.valid <= 1'b0;
    end else begin
      if (accept) begin
        accumulator <= items.last ? '0 : sum_next;
      end
      if (accept && items.last) begin
        stage.valid <= 1'b1;
        stage.sum   <= sum_next;
        stage.gain  <= items.gain;
      end else if (ready_down) begin
        stage.valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/beamdp_mul.sv
// Gain stage: registered signed 24x20 multiply of gain and sum.
// Depends on beamdp_pkg.
module beamdp_mul
  import beamdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sum_stage_t  stage_in,
  output logic        ready_up,
  input  logic        ready_down,
  output prod_stage_t stage
);

  logic load;

  assign ready_up = !stage.valid || ready_down;
  assign load     = stage_in.valid && ready_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      if (ready_up) begin
        stage.valid <= stage_in.valid;
      end
      if (load) begin
        stage.prod <= prod_t'(stage_in.gain) * prod_t'(stage_in.sum);
        stage.sum  <= stage_in.sum;
      end
    end
  end

endmodule

// File: rtl/beamdp_rnd.sv
// Output stage: round half to even from Q16, clamp to -7..7, result register.
// Depends on beamdp_pkg and beamdp_out_if.
module beamdp_rnd
  import beamdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  prod_stage_t  stage_in,
  output logic         ready_up,
  beamdp_out_if.source results
);

  qfloor_t                q_floor;
  logic [GAIN_FRAC-1:0]   frac;
  logic                   round_up;
  beam_t                  beam_next;
  logic                   load;

  localparam logic [GAIN_FRAC-1:0] HALF = {1'b1, {(GAIN_FRAC-1){1'b0}}};

  assign ready_up = !results.valid || results.ready;
  assign load     = stage_in.valid && ready_up;
  assign q_floor  = stage_in.prod[PROD_W-1:GAIN_FRAC];
  assign frac     = stage_in.prod[GAIN_FRAC-1:0];
  assign round_up = (frac > HALF) || ((frac == HALF) && q_floor[0]);

  // Clamp on the floor: floor >= 7 rounds to 7 or 8, floor <= -8 to -8 or -7.
  always_comb begin
    if (q_floor >= qfloor_t'(OUT_MAX)) begin
      beam_next = OUT_MAX;
    end else if (q_floor < qfloor_t'(OUT_MIN)) begin
      beam_next = OUT_MIN;
    end else begin
      beam_next = q_floor[OUT_W-1:0] + {{(OUT_W-1){1'b0}}, round_up};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ready_up) begin
      results.valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.beam_value <= beam_next;
      results.raw_sum    <= stage_in.sum;
    end
  end

endmodule

// File: rtl/beam_dot_product_gain_clamp_unit.sv
// Top level of the beam dot-product, gain and clamp unit.
// Depends on beamdp_pkg, beamdp_if.sv, beamdp_acc, beamdp_mul, beamdp_rnd.
`include "beam_dot_product_gain_clamp_unit_assert.svh"

// Accepts one weight/sample request per cycle while the sum stage is not
// stalled, and accumulates weight*sample into a 20-bit running sum (wraps
// modulo 2^20). The request with last set closes the beam element: its sum,
// including its own term, is multiplied by the Q8.16 gain, rounded to nearest
// with ties to even, clamped to -7..7 and delivered with the raw sum; the
// running sum then restarts at zero. Requests without last produce no result.
// Throughput is one request per clock while the input is not stalled; result
// valid rises once its sum has passed through the three registers in its
// path: the sum register, the registered gain multiply and the output
// register. Each stage holds its contents only while the stage after it is
// full and stalled, so input requests keep flowing while a result waits to be
// taken as long as an earlier stage has room.
module beam_dot_product_gain_clamp_unit
  import beamdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  beamdp_in_if.sink    items,
  beamdp_out_if.source results
);

  sum_stage_t  sum_stage;    // finished sum + gain
  prod_stage_t prod_stage;   // gain * sum, Q16
  logic        mul_ready;    // multiply stage can take a sum
  logic        rnd_ready;    // output stage can take a product

  // Stage 1: multiply-accumulate, captures the sum on last.
  beamdp_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .ready_down (mul_ready),
    .stage      (sum_stage)
  );

  // Stage 2: gain multiply.
  beamdp_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .stage_in   (sum_stage),
    .ready_up   (mul_ready),
    .ready_down (rnd_ready),
    .stage      (prod_stage)
  );

  // Stage 3: rounding, clamp and result register.
  beamdp_rnd u_rnd (
    .clk      (clk),
    .rst      (rst),
    .stage_in (prod_stage),
    .ready_up (rnd_ready),
    .results  (results)
  );

  // A taken last request always lands in the sum stage.
  `BEAMDP_ASSERT_NEXT(a_last_loads, clk, rst, items.valid && items.ready && items.last, sum_stage.valid)
  // A stalled product is not dropped.
  `BEAMDP_ASSERT_NEXT(a_prod_holds, clk, rst, prod_stage.valid && !rnd_ready, prod_stage.valid)
  // Clamp never lets -8 out.
  `BEAMDP_ASSERT_NOW(a_clamp_range, clk, rst, results.valid, results.beam_value != beam_t'(-8))
  // Input is blocked only when the sum stage is full and cannot drain.
  `BEAMDP_ASSERT_NOW(a_ready_rule, clk, rst, !items.ready, sum_stage.valid && !mul_ready)

endmodule
